// ===== src/pal_pkg.sv =====
// Shared types, codes, widths and the microcode table of the positional array list.
package pal_pkg;

    localparam int OP_W         = 2;
    localparam int POS_W        = 6;
    localparam int VAL_W        = 32;
    localparam int ST_W         = 2;
    localparam int LEN_W        = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // microprogram step addresses
    typedef enum logic [3:0] {
        U_IDLE      = 4'd0,
        U_APP       = 4'd1,
        U_INS_PRIME = 4'd2,
        U_INS_MOVE  = 4'd3,
        U_INS_PUT   = 4'd4,
        U_ERA_PRIME = 4'd5,
        U_ERA_MOVE  = 4'd6,
        U_ERA_FIN   = 4'd7,
        U_GET_RD    = 4'd8,
        U_GET_CAP   = 4'd9,
        U_RESP      = 4'd10
    } upc_t;

    typedef enum logic [1:0] {
        WA_INC   = 2'd0,   // ptr + 1
        WA_DEC   = 2'd1,   // ptr - 1
        WA_POS   = 2'd2,
        WA_COUNT = 2'd3
    } wa_sel_t;

    typedef enum logic {
        WD_VAL   = 1'b0,
        WD_RDATA = 1'b1
    } wd_sel_t;

    typedef enum logic [1:0] {
        RA_PTR = 2'd0,
        RA_DEC = 2'd1,
        RA_INC = 2'd2
    } ra_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD = 2'd0,
        PTR_DEC  = 2'd1,
        PTR_INC  = 2'd2
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,  // fall through
        J_GOTO     = 3'd1,  // unconditional
        J_BRANCH   = 3'd2,  // flag ? target : next
        J_LOOP     = 3'd3,  // flag ? target : stay
        J_DISPATCH = 3'd4   // decode incoming request
    } jmode_t;

    typedef enum logic [1:0] {
        F_PTR_EQ_POS     = 2'd0,
        F_PTR_EQ_CNT     = 2'd1,
        F_PTR_INC_EQ_CNT = 2'd2,
        F_OUT_FREE       = 2'd3
    } flag_t;

    typedef struct packed {
        logic    accept;
        logic    mem_we;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    mem_re;
        ra_sel_t ra_sel;
        ptr_op_t ptr_op;
        cnt_op_t cnt_op;
        logic    capture;
        logic    out_load;
        jmode_t  jmode;
        flag_t   flag_sel;
        upc_t    target;
    } ctl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic ptr_eq_pos;
        logic ptr_eq_cnt;
        logic ptr_inc_eq_cnt;
        logic req_ok;
    } flags_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        status_t                 status;
        logic [LEN_W-1:0]        length;
        logic                    empty_res;
    } res_t;

    // control store
    function automatic ctl_t ucode_rom(input upc_t upc);
        ctl_t c;
        c = '0;
        unique case (upc)
            U_IDLE: begin
                c.accept = 1'b1;
                c.jmode  = J_DISPATCH;
            end
            U_APP: begin
                c.mem_we = 1'b1;
                c.wa_sel = WA_COUNT;
                c.wd_sel = WD_VAL;
                c.cnt_op = CNT_INC;
                c.jmode  = J_GOTO;
                c.target = U_RESP;
            end
            U_INS_PRIME: begin
                c.mem_re = 1'b1;
                c.ra_sel = RA_PTR;
                c.jmode  = J_NEXT;
            end
            U_INS_MOVE: begin
                c.mem_we   = 1'b1;
                c.wa_sel   = WA_INC;
                c.wd_sel   = WD_RDATA;
                c.mem_re   = 1'b1;
                c.ra_sel   = RA_DEC;
                c.ptr_op   = PTR_DEC;
                c.jmode    = J_LOOP;
                c.flag_sel = F_PTR_EQ_POS;
                c.target   = U_INS_PUT;
            end
            U_INS_PUT: begin
                c.mem_we = 1'b1;
                c.wa_sel = WA_POS;
                c.wd_sel = WD_VAL;
                c.cnt_op = CNT_INC;
                c.jmode  = J_GOTO;
                c.target = U_RESP;
            end
            U_ERA_PRIME: begin
                c.mem_re   = 1'b1;
                c.ra_sel   = RA_PTR;
                c.jmode    = J_BRANCH;
                c.flag_sel = F_PTR_EQ_CNT;
                c.target   = U_ERA_FIN;
            end
            U_ERA_MOVE: begin
                c.mem_we   = 1'b1;
                c.wa_sel   = WA_DEC;
                c.wd_sel   = WD_RDATA;
                c.mem_re   = 1'b1;
                c.ra_sel   = RA_INC;
                c.ptr_op   = PTR_INC;
                c.jmode    = J_LOOP;
                c.flag_sel = F_PTR_INC_EQ_CNT;
                c.target   = U_ERA_FIN;
            end
            U_ERA_FIN: begin
                c.cnt_op = CNT_DEC;
                c.jmode  = J_GOTO;
                c.target = U_RESP;
            end
            U_GET_RD: begin
                c.mem_re = 1'b1;
                c.ra_sel = RA_PTR;
                c.jmode  = J_NEXT;
            end
            U_GET_CAP: begin
                c.capture = 1'b1;
                c.jmode   = J_GOTO;
                c.target  = U_RESP;
            end
            U_RESP: begin
                c.out_load = 1'b1;
                c.jmode    = J_LOOP;
                c.flag_sel = F_OUT_FREE;
                c.target   = U_IDLE;
            end
            default: begin
                c.jmode  = J_GOTO;
                c.target = U_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== src/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pal_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module pal_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [pal_pkg::OP_W-1:0] s_op,
    input  pal_pkg::flags_t   flags,
    input  logic              out_free,
    output pal_pkg::ctl_t     ctl
);
    import pal_pkg::*;

    upc_t upc_reg, upc_next;
    logic flag;

    assign ctl = ucode_rom(upc_reg);

    always_comb begin
        unique case (ctl.flag_sel)
            F_PTR_EQ_POS:     flag = flags.ptr_eq_pos;
            F_PTR_EQ_CNT:     flag = flags.ptr_eq_cnt;
            F_PTR_INC_EQ_CNT: flag = flags.ptr_inc_eq_cnt;
            F_OUT_FREE:       flag = out_free;
            default:          flag = 1'b0;
        endcase
    end

    always_comb begin
        upc_next = upc_reg;
        unique case (ctl.jmode)
            J_NEXT:   upc_next = upc_t'(upc_reg + 4'd1);
            J_GOTO:   upc_next = ctl.target;
            J_BRANCH: upc_next = flag ? ctl.target : upc_t'(upc_reg + 4'd1);
            J_LOOP:   upc_next = flag ? ctl.target : upc_reg;
            J_DISPATCH: begin
                if (s_valid) begin
                    if (!flags.req_ok) begin
                        upc_next = U_RESP;
                    end else begin
                        unique case (op_t'(s_op))
                            OP_APPEND: upc_next = U_APP;
                            OP_INSERT: upc_next = U_INS_PRIME;
                            OP_ERASE:  upc_next = U_ERA_PRIME;
                            OP_GET:    upc_next = U_GET_RD;
                            default:   upc_next = U_IDLE;
                        endcase
                    end
                end
            end
            default:  upc_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== src/pal_dpath.sv =====
// Datapath: request registers, walk pointer, entry count and the entry store.
module pal_dpath #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [pal_pkg::OP_W-1:0]      s_op,
    input  logic [pal_pkg::POS_W-1:0]     s_position,
    input  logic signed [pal_pkg::VAL_W-1:0] s_value,
    input  pal_pkg::ctl_t                 ctl,
    output pal_pkg::flags_t               flags,
    output pal_pkg::res_t                 res
);
    import pal_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           ptr_reg, ptr_next;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] rvalue_reg;
    status_t                 status_reg;

    logic                    acc;
    logic [CMP_W-1:0]        s_pos_ext;
    logic                    range_err;
    logic                    full;
    status_t                 req_status;
    logic [CW-1:0]           ptr_load;
    logic [CW-1:0]           ptr_dec;
    logic [CW-1:0]           ptr_inc;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [VAL_W-1:0]        mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [VAL_W-1:0]        mem_rdata;

    assign acc       = ctl.accept & s_valid;
    assign s_pos_ext = CMP_W'(s_position);
    assign range_err = s_pos_ext >= CMP_W'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign ptr_dec   = ptr_reg - CW'(1);
    assign ptr_inc   = ptr_reg + CW'(1);

    // range check wins over full for insert
    always_comb begin
        unique case (op_t'(s_op))
            OP_APPEND: req_status = full ? ST_FULL : ST_OK;
            OP_INSERT: req_status = range_err ? ST_RANGE : (full ? ST_FULL : ST_OK);
            OP_ERASE:  req_status = range_err ? ST_RANGE : ST_OK;
            OP_GET:    req_status = range_err ? ST_RANGE : ST_OK;
            default:   req_status = ST_OK;
        endcase
    end

    // insert walks down from the tail, erase walks up from position + 1
    always_comb begin
        unique case (op_t'(s_op))
            OP_INSERT: ptr_load = count_reg - CW'(1);
            OP_ERASE:  ptr_load = CW'(s_pos_ext + CMP_W'(1));
            OP_GET:    ptr_load = CW'(s_pos_ext);
            default:   ptr_load = count_reg;
        endcase
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (acc) begin
            ptr_next = ptr_load;
        end else begin
            unique case (ctl.ptr_op)
                PTR_HOLD: ptr_next = ptr_reg;
                PTR_DEC:  ptr_next = ptr_dec;
                PTR_INC:  ptr_next = ptr_inc;
                default:  ptr_next = ptr_reg;
            endcase
        end
    end

    always_comb begin
        unique case (ctl.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CW'(1);
            CNT_DEC:  count_next = count_reg - CW'(1);
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (acc) begin
            pos_reg    <= s_position;
            val_reg    <= s_value;
            status_reg <= req_status;
            rvalue_reg <= '0;
        end else if (ctl.capture) begin
            rvalue_reg <= mem_rdata;
        end
    end

    always_comb begin
        unique case (ctl.wa_sel)
            WA_INC:   mem_waddr = ptr_inc[AW-1:0];
            WA_DEC:   mem_waddr = ptr_dec[AW-1:0];
            WA_POS:   mem_waddr = AW'(pos_reg);
            WA_COUNT: mem_waddr = count_reg[AW-1:0];
            default:  mem_waddr = count_reg[AW-1:0];
        endcase
    end

    always_comb begin
        unique case (ctl.ra_sel)
            RA_PTR:  mem_raddr = ptr_reg[AW-1:0];
            RA_DEC:  mem_raddr = ptr_dec[AW-1:0];
            RA_INC:  mem_raddr = ptr_inc[AW-1:0];
            default: mem_raddr = ptr_reg[AW-1:0];
        endcase
    end

    assign mem_we    = ctl.mem_we;
    assign mem_wdata = (ctl.wd_sel == WD_RDATA) ? mem_rdata : val_reg;

    pal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (ctl.mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign flags.ptr_eq_pos     = (CMP_W'(ptr_reg) == CMP_W'(pos_reg));
    assign flags.ptr_eq_cnt     = (ptr_reg == count_reg);
    assign flags.ptr_inc_eq_cnt = (ptr_inc == count_reg);
    assign flags.req_ok         = (req_status == ST_OK);

    assign res.read_value = rvalue_reg;
    assign res.status     = status_reg;
    assign res.length     = LEN_W'(count_reg);
    assign res.empty_res  = (count_reg == '0);

endmodule

// ===== src/positional_array_list.sv =====
// Top level of the positional array list: sequencer, datapath and result register.
//
// Ordered list of signed 32-bit entries held in a store of CAPACITY words.
// Each request carries an op (append, insert, erase, get), a position and a
// value, and produces exactly one result with the value read (zero unless a
// get succeeds), a status (ok, index out of range, store full), the length
// after the request and an empty flag. An insert or erase position must be
// below the current length; a bad position is checked before a full store.
// Requests are handled one at a time by a small microprogram that steps the
// store's single read and single write port. An insert moves the entries
// from the tail down to its position up by one and then writes the value;
// an erase moves the entries above its position down by one. This shift
// walk moves one entry per cycle, so an insert or erase near the head of a
// long list takes longest. The result sits in an output register, so a
// new request is taken while the previous result still waits on m_ready; a
// request whose result finds that register still occupied holds in its last
// step until m_ready frees it.
// No clearing pass is needed after reset: only entries below the length are
// ever used, and those were written first.
module positional_array_list #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pal_pkg::OP_W-1:0]          s_op,
    input  logic [pal_pkg::POS_W-1:0]         s_position,
    input  logic signed [pal_pkg::VAL_W-1:0]  s_value,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pal_pkg::VAL_W-1:0]  m_read_value,
    output logic [pal_pkg::ST_W-1:0]          m_status,
    output logic [pal_pkg::LEN_W-1:0]         m_length,
    output logic                              m_empty_res
);
    import pal_pkg::*;

    ctl_t   ctl;
    flags_t flags;
    res_t   res;

    logic   m_valid_reg, m_valid_next;
    res_t   m_res_reg;
    logic   out_free;
    logic   out_load;

    // result slot can take a new result when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ctl.out_load && out_free;

    // requests are taken only at the idle step of the microprogram
    assign s_ready = ctl.accept;

    pal_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_op     (s_op),
        .flags    (flags),
        .out_free (out_free),
        .ctl      (ctl)
    );

    pal_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_op       (s_op),
        .s_position (s_position),
        .s_value    (s_value),
        .ctl        (ctl),
        .flags      (flags),
        .res        (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_res_reg.read_value;
    assign m_status     = m_res_reg.status;
    assign m_length     = m_res_reg.length;
    assign m_empty_res  = m_res_reg.empty_res;

`ifndef NO_ASSERTIONS
    // one request in flight: ready drops right after a request is taken
    property p_one_in_flight;
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("request taken while another is in progress");

    // only a successful get returns data
    property p_read_zero;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_read_value == '0);
    endproperty
    a_read_zero: assert property (p_read_zero)
        else $error("nonzero read value on a failed request");

    // a full refusal reports the store at capacity
    property p_full_len;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_length == LEN_W'(CAPACITY));
    endproperty
    a_full_len: assert property (p_full_len)
        else $error("full status with length below capacity");

    // results never carry an undefined status code
    property p_status_code;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == ST_OK) || (m_status == ST_RANGE) ||
                     (m_status == ST_FULL));
    endproperty
    a_status_code: assert property (p_status_code)
        else $error("undefined status code on result");
`endif

endmodule
